### sv/itda_pkg.sv
// shared types and constants for the integer to decimal ascii converter
package itda_pkg;

    localparam int unsigned VALUE_W       = 32;
    localparam int unsigned CHAR_W        = 8;
    localparam int unsigned NUM_DIGITS    = 10;
    localparam int unsigned BCD_W         = 4 * NUM_DIGITS;
    localparam int unsigned BITS_PER_STEP = 8;
    localparam int unsigned NUM_STEPS     = VALUE_W / BITS_PER_STEP;
    localparam int unsigned STEP_W        = $clog2(NUM_STEPS);
    localparam int unsigned IDX_W         = $clog2(NUM_DIGITS);

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;

    typedef struct packed {
        logic load;
        logic step;
        logic prep;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic conv_done;
        logic emit_last;
    } t_sts;

endpackage

### sv/int_to_decimal_ascii.sv
// Converts one signed 32-bit integer per input item into its decimal ASCII text,
// one character per output item, most significant first, with a leading '-' for
// negative values and tlast on the final digit. An item has n (1 to 11)
// characters and passes through these steps: accept, conversion in the
// binary-to-bcd unit (eight shift-add-3 steps per cycle), finding the leading
// digit, then one character per cycle on the byte-wide output unless it stalls.
// A new input is accepted as soon as the last character is loaded into the
// output register, even while that character still waits to be taken.
module int_to_decimal_ascii (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [31:0] value
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // [7:0] char_byte
    output logic        o_m_axis_tlast
);

    itda_pkg::t_cmd cmd;
    itda_pkg::t_sts sts;

    itda_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    itda_dp u_dp (
        .i_clk   (i_clk),
        .i_value (i_s_axis_tdata),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_char  (o_m_axis_tdata),
        .o_last  (o_m_axis_tlast)
    );

endmodule

### sv/itda_dp.sv
// datapath: magnitude, double-dabble bcd unit and character output register
module itda_dp (
    input  logic                              i_clk,
    input  logic [itda_pkg::VALUE_W-1:0]      i_value,
    input  itda_pkg::t_cmd                    i_cmd,
    output itda_pkg::t_sts                    o_sts,
    output logic [itda_pkg::CHAR_W-1:0]       o_char,
    output logic                              o_last
);

    logic [itda_pkg::VALUE_W-1:0] r_mag, n_mag;
    logic [itda_pkg::BCD_W-1:0]   r_bcd, n_bcd;
    logic [itda_pkg::STEP_W-1:0]  r_step;
    logic [itda_pkg::IDX_W-1:0]   r_idx;
    logic [itda_pkg::IDX_W-1:0]   msd_idx;
    logic                         r_neg;
    logic                         r_sign_pend;
    logic [itda_pkg::CHAR_W-1:0]  r_char;
    logic                         r_last;
    logic [3:0]                   cur_digit;
    logic [itda_pkg::CHAR_W-1:0]  cur_char;
    logic                         cur_last;

    // eight shift-add-3 steps per cycle
    always_comb begin
        n_bcd = r_bcd;
        n_mag = r_mag;
        for (int k = 0; k < itda_pkg::BITS_PER_STEP; k++) begin
            for (int d = 0; d < itda_pkg::NUM_DIGITS; d++) begin
                if (n_bcd[d*4 +: 4] >= 4'd5) begin
                    n_bcd[d*4 +: 4] = n_bcd[d*4 +: 4] + 4'd3;
                end
            end
            n_bcd = {n_bcd[itda_pkg::BCD_W-2:0], n_mag[itda_pkg::VALUE_W-1]};
            n_mag = {n_mag[itda_pkg::VALUE_W-2:0], 1'b0};
        end
    end

    // most significant nonzero digit, zero when all digits are zero
    always_comb begin
        msd_idx = '0;
        for (int d = 0; d < itda_pkg::NUM_DIGITS; d++) begin
            if (r_bcd[d*4 +: 4] != 4'd0) begin
                msd_idx = itda_pkg::IDX_W'(d);
            end
        end
    end

    assign cur_digit = r_bcd[r_idx*4 +: 4];
    assign cur_char  = r_sign_pend ? itda_pkg::CHAR_MINUS
                                   : itda_pkg::CHAR_ZERO + {4'd0, cur_digit};
    assign cur_last  = !r_sign_pend && (r_idx == '0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_neg  <= i_value[itda_pkg::VALUE_W-1];
            r_mag  <= i_value[itda_pkg::VALUE_W-1] ? (~i_value + 1'b1) : i_value;
            r_bcd  <= '0;
            r_step <= '0;
        end else if (i_cmd.step) begin
            r_mag  <= n_mag;
            r_bcd  <= n_bcd;
            r_step <= r_step + 1'b1;
        end
        if (i_cmd.prep) begin
            r_idx       <= msd_idx;
            r_sign_pend <= r_neg;
        end else if (i_cmd.emit) begin
            r_char <= cur_char;
            r_last <= cur_last;
            if (r_sign_pend) begin
                r_sign_pend <= 1'b0;
            end else begin
                r_idx <= r_idx - 1'b1;
            end
        end
    end

    assign o_sts.conv_done = (r_step == itda_pkg::STEP_W'(itda_pkg::NUM_STEPS - 1));
    assign o_sts.emit_last = cur_last;
    assign o_char          = r_char;
    assign o_last          = r_last;

endmodule

### sv/itda_ctrl.sv
// controller: state machine sequencing load, conversion and character output
module itda_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output itda_pkg::t_cmd o_cmd,
    input  itda_pkg::t_sts i_sts
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CONV = 2'd1;
    localparam logic [1:0] S_PREP = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    logic [1:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CONV;
                end
            end
            S_CONV: begin
                o_cmd.step = 1'b1;
                if (i_sts.conv_done) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = S_EMIT;
            end
            S_EMIT: begin
                o_cmd.emit = !r_out_valid || i_out_ready;
                if (o_cmd.emit && i_sts.emit_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        n_out_valid = o_cmd.emit || (r_out_valid && !i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    a_last_ends_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && o_cmd.emit && i_sts.emit_last) |=> r_state == S_IDLE)
        else $error("last character did not return controller to idle");

    a_emit_needs_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> (!r_out_valid || i_out_ready))
        else $error("character overwritten before being taken");

    a_valid_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(o_cmd.emit))
        else $error("output valid raised without an emit");

    a_conv_then_prep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CONV && i_sts.conv_done) |=> r_state == S_PREP)
        else $error("conversion end not followed by prep");

endmodule
